FILE: rtl/core/vfgf_pkg.sv
`default_nettype none

package vfgf_pkg;

  localparam int unsigned CYCLE_LENGTH = 21;
  localparam int unsigned MAX_RESULTS  = 19;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam int unsigned POS_W      = 5;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned SEQ_END_BIT = 6;

  localparam logic [1:0] OP_HEADER   = 2'd0;
  localparam logic [1:0] OP_DATA     = 2'd1;
  localparam logic [1:0] OP_WATCHDOG = 2'd2;

  localparam logic [2:0] KIND_SILENCE = 3'd0;
  localparam logic [2:0] KIND_REPEAT  = 3'd1;
  localparam logic [2:0] KIND_FRAME   = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_HEADER  = 3'd4;
  localparam logic [2:0] KIND_BADSEQ  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_FILL_THRESH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LATE_LIMIT  = 2'd1;

  localparam logic [CFG_DATA_W-1:0] FILL_THRESH_RST = 5'd2;
  localparam logic [CFG_DATA_W-1:0] LATE_LIMIT_RST  = 5'd18;
  localparam logic [CFG_DATA_W-1:0] LATE_CAP = CFG_DATA_W'(MAX_RESULTS - 1);

  typedef enum logic [2:0] {
    CMD_HEADER,
    CMD_END,
    CMD_WATCHDOG,
    CMD_BADSEQ,
    CMD_FRAME
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] seq_field;
  } in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic               sync_insert;
    logic               queue_index;
    logic               last;
    logic [COUNT_W-1:0] packet_count;
    logic [COUNT_W-1:0] silence_count;
  } out_t;

endpackage

`default_nettype wire

FILE: rtl/core/voice_frame_sequence_gap_filler_unit.sv
// Voice frame sequence gap filler.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one event per
// transaction: header, data frame with raw sequence byte, or watchdog expiry.
// Output channel (out_valid_o / out_stall_i / out_data_o) returns frame
// descriptors, with last set on the final descriptor of each event.
// Config channel (cfg_valid_i / cfg_ready_o) writes the fill threshold
// (index 0) and late_limit (index 1); write only while the block is idle.
// Accepted events enter a two-entry command queue; input stalls only when
// it is full. The back-end sequencer emits descriptors one at a time into
// an output register: header, end and bad-sequence events give a single
// descriptor, a frame with gap g gives g fillers then the frame itself,
// and a dropped frame gives none. Events are registered in the queue
// before the sequencer pops them. A stalled output holds its descriptor
// and freezes the sequencer; the queue keeps taking events until full.
// Reset clears the queue, the output register, the position, mode, queue
// selector and counters, and loads thresholds 2 and 18.
`default_nettype none

module voice_frame_sequence_gap_filler_unit #(
  parameter int unsigned CycleLength = vfgf_pkg::CYCLE_LENGTH,
  parameter int unsigned QueueDepth  = vfgf_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire vfgf_pkg::in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output vfgf_pkg::out_t                       out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [vfgf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [vfgf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [vfgf_pkg::CFG_DATA_W-1:0] fill_thresh_q;
  logic [vfgf_pkg::CFG_DATA_W-1:0] late_limit_q;

  logic           push, queue_full, cmd_valid, cmd_pop;
  vfgf_pkg::cmd_t push_cmd, head_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_thresh_q <= vfgf_pkg::FILL_THRESH_RST;
      late_limit_q  <= vfgf_pkg::LATE_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vfgf_pkg::CFG_FILL_THRESH: fill_thresh_q <= cfg_data_i;
        vfgf_pkg::CFG_LATE_LIMIT:  late_limit_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  vfgf_front #(
    .CycleLength(CycleLength)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .queue_full_i(queue_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  vfgf_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (queue_full),
    .valid_o(cmd_valid),
    .pop_i  (cmd_pop),
    .data_o (head_cmd)
  );

  vfgf_back #(
    .CycleLength(CycleLength)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (head_cmd),
    .cmd_pop_o    (cmd_pop),
    .fill_thresh_i(fill_thresh_q),
    .late_limit_i (late_limit_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/vfgf_front.sv
`default_nettype none

module vfgf_front #(
  parameter int unsigned CycleLength = vfgf_pkg::CYCLE_LENGTH
) (
  input  wire logic           in_valid_i,
  input  wire vfgf_pkg::in_t  in_data_i,
  output logic                in_stall_o,
  input  wire logic           queue_full_i,
  output logic                push_o,
  output vfgf_pkg::cmd_t      cmd_o
);

  logic [vfgf_pkg::POS_W-1:0] pos;
  logic                       pos_bad;
  logic                       known;

  assign pos        = in_data_i.seq_field[vfgf_pkg::POS_W-1:0];
  assign pos_bad    = {1'b0, pos} >= (vfgf_pkg::POS_W + 1)'(CycleLength);
  assign in_stall_o = queue_full_i;

  always_comb begin
    known      = 1'b1;
    cmd_o.pos  = pos;
    cmd_o.cmd  = vfgf_pkg::CMD_HEADER;
    case (in_data_i.operation)
      vfgf_pkg::OP_HEADER: begin
        cmd_o.cmd = vfgf_pkg::CMD_HEADER;
      end
      vfgf_pkg::OP_DATA: begin
        if (in_data_i.seq_field[vfgf_pkg::SEQ_END_BIT]) begin
          cmd_o.cmd = vfgf_pkg::CMD_END;
        end else if (pos_bad) begin
          cmd_o.cmd = vfgf_pkg::CMD_BADSEQ;
        end else begin
          cmd_o.cmd = vfgf_pkg::CMD_FRAME;
        end
      end
      vfgf_pkg::OP_WATCHDOG: begin
        cmd_o.cmd = vfgf_pkg::CMD_WATCHDOG;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign push_o = in_valid_i && !queue_full_i && known;

endmodule

`default_nettype wire

FILE: rtl/core/vfgf_queue.sv
`default_nettype none

module vfgf_queue #(
  parameter int unsigned Depth = vfgf_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire vfgf_pkg::cmd_t  data_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            pop_i,
  output vfgf_pkg::cmd_t       data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  vfgf_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vfgf_back.sv
`default_nettype none

module vfgf_back #(
  parameter int unsigned CycleLength = vfgf_pkg::CYCLE_LENGTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cmd_valid_i,
  input  wire vfgf_pkg::cmd_t                  cmd_i,
  output logic                                 cmd_pop_o,
  input  wire logic [vfgf_pkg::CFG_DATA_W-1:0] fill_thresh_i,
  input  wire logic [vfgf_pkg::CFG_DATA_W-1:0] late_limit_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output vfgf_pkg::out_t                       out_data_o
);

  localparam int unsigned PosW = vfgf_pkg::POS_W;
  localparam int unsigned CntW = vfgf_pkg::COUNT_W;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e          state_q, state_d;
  logic [PosW-1:0] exp_q, exp_d;
  logic            net_q, net_d;
  logic            wq_q, wq_d;
  logic [CntW-1:0] frames_q, frames_d;
  logic [CntW-1:0] fillers_q, fillers_d;
  logic [PosW-1:0] remain_q, remain_d;
  logic [2:0]      filler_kind_q, filler_kind_d;
  logic            out_valid_q, out_valid_d;
  vfgf_pkg::out_t  out_q, out_d;

  logic            out_free;
  logic [CntW-1:0] frames_inc, fillers_inc;
  logic [PosW:0]   exp_wide, pos_w, exp_w, gap_w;
  logic [PosW-1:0] exp_next, gap;
  logic [vfgf_pkg::CFG_DATA_W-1:0] limit;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign frames_inc  = (frames_q == '1) ? frames_q : frames_q + CntW'(1);
  assign fillers_inc = (fillers_q == '1) ? fillers_q : fillers_q + CntW'(1);
  assign exp_wide    = {1'b0, exp_q} + (PosW + 1)'(1);
  assign exp_next    = (exp_wide == (PosW + 1)'(CycleLength)) ? '0 : exp_wide[PosW-1:0];
  assign pos_w       = {1'b0, cmd_i.pos};
  assign exp_w       = {1'b0, exp_q};
  assign gap_w       = (pos_w >= exp_w) ? pos_w - exp_w
                                        : pos_w + (PosW + 1)'(CycleLength) - exp_w;
  assign gap         = gap_w[PosW-1:0];
  assign limit       = (late_limit_i > vfgf_pkg::LATE_CAP) ? vfgf_pkg::LATE_CAP
                                                           : late_limit_i;

  always_comb begin
    state_d       = state_q;
    exp_d         = exp_q;
    net_d         = net_q;
    wq_d          = wq_q;
    frames_d      = frames_q;
    fillers_d     = fillers_q;
    remain_d      = remain_q;
    filler_kind_d = filler_kind_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_d         = out_q;
    cmd_pop_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.cmd)
            vfgf_pkg::CMD_HEADER: begin
              net_d       = 1'b1;
              exp_d       = '0;
              frames_d    = '0;
              fillers_d   = '0;
              out_valid_d = 1'b1;
              out_d       = '{kind: vfgf_pkg::KIND_HEADER, sync_insert: 1'b0,
                              queue_index: wq_q, last: 1'b1,
                              packet_count: '0, silence_count: '0};
            end
            vfgf_pkg::CMD_END: begin
              frames_d    = frames_inc;
              net_d       = 1'b0;
              wq_d        = ~wq_q;
              out_valid_d = 1'b1;
              out_d       = '{kind: vfgf_pkg::KIND_END, sync_insert: 1'b0,
                              queue_index: wq_q, last: 1'b1,
                              packet_count: frames_inc, silence_count: fillers_q};
            end
            vfgf_pkg::CMD_WATCHDOG: begin
              if (net_q) begin
                net_d       = 1'b0;
                wq_d        = ~wq_q;
                out_valid_d = 1'b1;
                out_d       = '{kind: vfgf_pkg::KIND_END, sync_insert: 1'b0,
                                queue_index: wq_q, last: 1'b1,
                                packet_count: frames_q, silence_count: fillers_q};
              end
            end
            vfgf_pkg::CMD_BADSEQ: begin
              out_valid_d = 1'b1;
              out_d       = '{kind: vfgf_pkg::KIND_BADSEQ, sync_insert: 1'b0,
                              queue_index: wq_q, last: 1'b1,
                              packet_count: frames_q, silence_count: fillers_q};
            end
            vfgf_pkg::CMD_FRAME: begin
              if (gap <= limit) begin
                remain_d      = gap;
                filler_kind_d = (gap > fill_thresh_i) ? vfgf_pkg::KIND_SILENCE
                                                      : vfgf_pkg::KIND_REPEAT;
                state_d       = ST_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (out_free) begin
          frames_d    = frames_inc;
          exp_d       = exp_next;
          out_valid_d = 1'b1;
          if (remain_q != '0) begin
            fillers_d = fillers_inc;
            remain_d  = remain_q - PosW'(1);
            out_d     = '{kind: filler_kind_q, sync_insert: exp_q == '0,
                          queue_index: wq_q, last: 1'b0,
                          packet_count: frames_inc, silence_count: fillers_inc};
          end else begin
            state_d = ST_IDLE;
            out_d   = '{kind: vfgf_pkg::KIND_FRAME, sync_insert: exp_q == '0,
                        queue_index: wq_q, last: 1'b1,
                        packet_count: frames_inc, silence_count: fillers_q};
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      exp_q         <= '0;
      net_q         <= 1'b0;
      wq_q          <= 1'b0;
      frames_q      <= '0;
      fillers_q     <= '0;
      remain_q      <= '0;
      filler_kind_q <= vfgf_pkg::KIND_SILENCE;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      state_q       <= state_d;
      exp_q         <= exp_d;
      net_q         <= net_d;
      wq_q          <= wq_d;
      frames_q      <= frames_d;
      fillers_q     <= fillers_d;
      remain_q      <= remain_d;
      filler_kind_q <= filler_kind_d;
      out_valid_q   <= out_valid_d;
      out_q         <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/vfgf_checker.sv
`default_nettype none

module vfgf_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire vfgf_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled output payload changed");

  a_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == vfgf_pkg::KIND_HEADER |->
      out_data_o.last && !out_data_o.sync_insert &&
      out_data_o.packet_count == '0 && out_data_o.silence_count == '0)
    else $error("header descriptor with stale counters");

  a_filler_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == vfgf_pkg::KIND_SILENCE ||
                    out_data_o.kind == vfgf_pkg::KIND_REPEAT) |->
      !out_data_o.last && out_data_o.silence_count != '0)
    else $error("filler descriptor ends a transaction");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == vfgf_pkg::KIND_END ||
                    out_data_o.kind == vfgf_pkg::KIND_BADSEQ) |->
      out_data_o.last && !out_data_o.sync_insert)
    else $error("end or bad-sequence descriptor malformed");

endmodule

bind voice_frame_sequence_gap_filler_unit vfgf_checker u_checker (.*);

`default_nettype wire

FILE: tb/tb_voice_frame_sequence_gap_filler_unit.sv
`timescale 1ns / 100ps

module tb_voice_frame_sequence_gap_filler_unit;

  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned SETTLE_CYCLES = 60;

  logic clk_i;
  logic rst_ni;

  logic in_valid;
  logic in_stall;
  vfgf_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  vfgf_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [vfgf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vfgf_pkg::CFG_DATA_W-1:0] cfg_data;

  voice_frame_sequence_gap_filler_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // Predicted block state
  logic [vfgf_pkg::POS_W-1:0] fr_pos;
  logic fr_net;
  logic fr_wq;
  logic [vfgf_pkg::COUNT_W-1:0] fr_frames;
  logic [vfgf_pkg::COUNT_W-1:0] fr_fillers;
  logic [vfgf_pkg::CFG_DATA_W-1:0] thr_reg;
  logic [vfgf_pkg::CFG_DATA_W-1:0] late_reg;

  vfgf_pkg::out_t expected_desc[$];
  int mismatch_count;

  bit in_idle_en;
  bit out_idle_en;
  bit hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [vfgf_pkg::COUNT_W-1:0] sat_inc16(
      logic [vfgf_pkg::COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic vfgf_pkg::out_t make_desc(logic [2:0] kind, logic sync);
    vfgf_pkg::out_t d;
    d.kind = kind;
    d.sync_insert = sync;
    d.queue_index = fr_wq;
    d.last = 1'b0;
    d.packet_count = fr_frames;
    d.silence_count = fr_fillers;
    return d;
  endfunction

  function automatic void advance_position();
    fr_pos = (fr_pos >= vfgf_pkg::CYCLE_LENGTH - 1) ? '0 : fr_pos + 1'b1;
  endfunction

  function automatic void predict_descriptors(vfgf_pkg::in_t ev);
    vfgf_pkg::out_t batch[$];
    logic [vfgf_pkg::POS_W-1:0] pos;
    int unsigned gap;
    int unsigned lim;
    logic [2:0] fill_kind;
    case (ev.operation)
      vfgf_pkg::OP_HEADER: begin
        fr_net = 1'b1;
        fr_pos = '0;
        fr_frames = '0;
        fr_fillers = '0;
        batch.push_back(make_desc(vfgf_pkg::KIND_HEADER, 1'b0));
      end
      vfgf_pkg::OP_DATA: begin
        if (ev.seq_field[vfgf_pkg::SEQ_END_BIT]) begin
          fr_frames = sat_inc16(fr_frames);
          batch.push_back(make_desc(vfgf_pkg::KIND_END, 1'b0));
          fr_net = 1'b0;
          fr_wq = ~fr_wq;
        end else begin
          pos = ev.seq_field[vfgf_pkg::POS_W-1:0];
          if (pos >= vfgf_pkg::CYCLE_LENGTH) begin
            batch.push_back(make_desc(vfgf_pkg::KIND_BADSEQ, 1'b0));
          end else begin
            if (fr_pos >= vfgf_pkg::CYCLE_LENGTH) fr_pos = '0;
            gap = (pos >= fr_pos) ? pos - fr_pos
                                  : pos + vfgf_pkg::CYCLE_LENGTH - fr_pos;
            lim = (late_reg > vfgf_pkg::LATE_CAP) ? vfgf_pkg::LATE_CAP : late_reg;
            if (gap <= lim) begin
              fill_kind = (gap > thr_reg) ? vfgf_pkg::KIND_SILENCE : vfgf_pkg::KIND_REPEAT;
              repeat (gap) begin
                fr_frames = sat_inc16(fr_frames);
                fr_fillers = sat_inc16(fr_fillers);
                batch.push_back(make_desc(fill_kind, fr_pos == '0));
                advance_position();
              end
              fr_frames = sat_inc16(fr_frames);
              batch.push_back(make_desc(vfgf_pkg::KIND_FRAME, fr_pos == '0));
              advance_position();
            end
          end
        end
      end
      vfgf_pkg::OP_WATCHDOG: begin
        if (fr_net) begin
          batch.push_back(make_desc(vfgf_pkg::KIND_END, 1'b0));
          fr_net = 1'b0;
          fr_wq = ~fr_wq;
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_desc.push_back(batch[i]);
  endfunction

  // Receiver side: random stall bursts, plus one long hold-off on request
  always begin
    @(posedge clk_i);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_req = 1'b0;
      out_stall <= 1'b0;
    end else if (out_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    vfgf_pkg::out_t exp_d;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_desc.size() == 0) begin
        mismatch_count++;
        $display("%0t: mismatch exp none got kind=%0d sync=%0b q=%0b last=%0b pkt=%0d sil=%0d",
                 $time, out_data.kind, out_data.sync_insert, out_data.queue_index,
                 out_data.last, out_data.packet_count, out_data.silence_count);
      end else begin
        exp_d = expected_desc.pop_front();
        if (out_data.kind !== exp_d.kind || out_data.sync_insert !== exp_d.sync_insert ||
            out_data.queue_index !== exp_d.queue_index || out_data.last !== exp_d.last ||
            out_data.packet_count !== exp_d.packet_count ||
            out_data.silence_count !== exp_d.silence_count) begin
          mismatch_count++;
          $display("%0t: mismatch exp kind=%0d sync=%0b q=%0b last=%0b pkt=%0d sil=%0d",
                   $time, exp_d.kind, exp_d.sync_insert, exp_d.queue_index, exp_d.last,
                   exp_d.packet_count, exp_d.silence_count);
          $display("%0t:          got kind=%0d sync=%0b q=%0b last=%0b pkt=%0d sil=%0d",
                   $time, out_data.kind, out_data.sync_insert, out_data.queue_index,
                   out_data.last, out_data.packet_count, out_data.silence_count);
        end
      end
    end
  end

  task automatic send_event(logic [1:0] op, logic [7:0] seq);
    vfgf_pkg::in_t ev;
    ev.operation = op;
    ev.seq_field = seq;
    if (in_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_data <= ev;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict_descriptors(ev);
  endtask

  task automatic wait_drain(int unsigned pad);
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_desc.size() != 0);
    repeat (pad) @(posedge clk_i);
  endtask

  task automatic configure(logic [vfgf_pkg::CFG_DATA_W-1:0] thr,
                           logic [vfgf_pkg::CFG_DATA_W-1:0] late);
    wait_drain(SETTLE_CYCLES);
    cfg_index <= vfgf_pkg::CFG_FILL_THRESH;
    cfg_data <= thr;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    thr_reg = thr;
    cfg_index <= vfgf_pkg::CFG_LATE_LIMIT;
    cfg_data <= late;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    late_reg = late;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed streams with random skips, some ends, headers and noise
  task automatic send_stream(int n, int noise_pct);
    int unsigned sp;
    int unsigned skip;
    int unsigned r;
    logic [7:0] seq;
    sp = 0;
    send_event(vfgf_pkg::OP_HEADER, 8'($urandom_range(0, 255)));
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < noise_pct) begin
        send_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else if (r < noise_pct + 3) begin
        send_event(vfgf_pkg::OP_DATA, 8'($urandom_range(0, 255)) | 8'h40);
      end else if (r < noise_pct + 5) begin
        send_event(vfgf_pkg::OP_WATCHDOG, 8'($urandom_range(0, 255)));
      end else if (r < noise_pct + 9) begin
        sp = 0;
        send_event(vfgf_pkg::OP_HEADER, 8'($urandom_range(0, 255)));
      end else begin
        r = $urandom_range(0, 9);
        skip = (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 4) : $urandom_range(5, 20);
        sp = (sp + skip) % vfgf_pkg::CYCLE_LENGTH;
        seq = {1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)), 5'(sp)};
        send_event(vfgf_pkg::OP_DATA, seq);
        sp = (sp + 1) % vfgf_pkg::CYCLE_LENGTH;
      end
    end
  endtask

  task automatic test_directed();
    send_event(vfgf_pkg::OP_WATCHDOG, 8'h00);
    send_event(vfgf_pkg::OP_HEADER, 8'h00);
    send_event(vfgf_pkg::OP_DATA, 8'h00);
    send_event(vfgf_pkg::OP_DATA, 8'h01);
    send_event(vfgf_pkg::OP_DATA, 8'h03);
    send_event(vfgf_pkg::OP_DATA, 8'h07);
    send_event(vfgf_pkg::OP_DATA, 8'h15);
    send_event(vfgf_pkg::OP_DATA, 8'h1F);
    send_event(vfgf_pkg::OP_DATA, 8'hBF);
    send_event(vfgf_pkg::OP_DATA, 8'h28);
    send_event(vfgf_pkg::OP_DATA, 8'h07);
    send_event(vfgf_pkg::OP_DATA, 8'h06);
    send_event(vfgf_pkg::OP_DATA, 8'h40);
    send_event(vfgf_pkg::OP_WATCHDOG, 8'hFF);
    send_event(vfgf_pkg::OP_DATA, 8'h05);
    send_event(vfgf_pkg::OP_HEADER, 8'h55);
    send_event(vfgf_pkg::OP_DATA, 8'h8A);
    send_event(2'd3, 8'hFF);
    send_event(vfgf_pkg::OP_DATA, 8'hFF);
    send_event(vfgf_pkg::OP_HEADER, 8'hAA);
    send_event(vfgf_pkg::OP_WATCHDOG, 8'h00);
    send_event(vfgf_pkg::OP_HEADER, 8'h00);
    send_event(vfgf_pkg::OP_DATA, 8'h14);
    send_event(vfgf_pkg::OP_DATA, 8'h00);
    send_event(vfgf_pkg::OP_DATA, 8'hC0);
  endtask

  task automatic test_config_sweep();
    configure(5'd0, 5'd0);
    send_stream(30, 10);
    configure(5'd20, 5'd20);
    send_stream(30, 10);
    configure(5'd31, 5'd31);
    send_stream(30, 10);
    configure(5'd0, 5'd18);
    send_stream(30, 10);
    configure(5'($urandom_range(0, 20)), 5'($urandom_range(0, 20)));
    send_stream(30, 10);
    configure(vfgf_pkg::FILL_THRESH_RST, vfgf_pkg::LATE_LIMIT_RST);
  endtask

  task automatic test_random();
    repeat (5) begin
      send_stream(30, 20);
      configure(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
    end
  endtask

  task automatic test_backpressure();
    in_idle_en = 1'b0;
    hold_req = 1'b1;
    send_event(vfgf_pkg::OP_HEADER, 8'h00);
    send_event(vfgf_pkg::OP_DATA, 8'h04);
    send_event(vfgf_pkg::OP_DATA, 8'h0C);
    send_event(vfgf_pkg::OP_DATA, 8'h0D);
    send_event(vfgf_pkg::OP_DATA, 8'h15);
    send_event(vfgf_pkg::OP_DATA, 8'h10);
    send_event(vfgf_pkg::OP_DATA, 8'h02);
    send_event(vfgf_pkg::OP_WATCHDOG, 8'h00);
    send_event(vfgf_pkg::OP_HEADER, 8'h00);
    send_event(vfgf_pkg::OP_DATA, 8'h12);
    send_event(vfgf_pkg::OP_DATA, 8'h13);
    send_event(vfgf_pkg::OP_DATA, 8'h40);
    wait_drain(0);
    in_idle_en = 1'b1;
    send_stream(10, 10);
  endtask

  task automatic test_quiet_tail();
    wait_drain(0);
    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    send_stream(40, 10);
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    hold_req = 1'b0;
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    mismatch_count = 0;
    fr_pos = '0;
    fr_net = 1'b0;
    fr_wq = 1'b0;
    fr_frames = '0;
    fr_fillers = '0;
    thr_reg = vfgf_pkg::FILL_THRESH_RST;
    late_reg = vfgf_pkg::LATE_LIMIT_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config_sweep();
    test_random();
    test_backpressure();
    test_quiet_tail();

    wait_drain(SETTLE_CYCLES);
    if (mismatch_count == 0 && expected_desc.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
